[hw/rtl/soa_pkg.sv]
// ----------------------------------------------------------------------------
// soa_pkg
// Shared constants, micro-operation codes and types of the slab allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package soa_pkg;

    localparam int NUM_PAGES    = 16;
    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_SLOTS    = 1024;
    localparam int HEADER_BYTES = 24;

    localparam int PG_W   = $clog2(NUM_PAGES);
    localparam int PGL_W  = PG_W + 1;
    localparam int SL_W   = $clog2(MAX_SLOTS);
    localparam int SLC_W  = SL_W + 1;
    localparam int OFF_W  = $clog2(PAGE_BYTES);
    localparam int DIV_W  = OFF_W + 1;
    localparam int WIDE_W = 17;
    localparam int OBJ_W  = 13;
    localparam int ALG_W  = 4;

    localparam logic [PGL_W-1:0] PG_NONE = PGL_W'(NUM_PAGES);
    localparam logic [SLC_W-1:0] SL_NONE = SLC_W'(MAX_SLOTS);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_SHRINK = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOPAGE  = 2'd2;

    localparam logic [1:0] LST_FULL    = 2'd1;
    localparam logic [1:0] LST_PARTIAL = 2'd2;
    localparam logic [1:0] LST_EMPTY   = 2'd3;

    localparam logic [0:0] REG_OBJECT_BYTES = 1'd0;
    localparam logic [0:0] REG_ALIGN_LOG2   = 1'd1;

    localparam logic [4:0] C_NOP        = 5'd0;
    localparam logic [4:0] C_LOAD       = 5'd1;
    localparam logic [4:0] C_CFG_WR     = 5'd2;
    localparam logic [4:0] C_CDIV_START = 5'd3;
    localparam logic [4:0] C_DIV_STEP   = 5'd4;
    localparam logic [4:0] C_CFG_DONE   = 5'd5;
    localparam logic [4:0] C_FDIV_START = 5'd6;
    localparam logic [4:0] C_SEL_PART   = 5'd7;
    localparam logic [4:0] C_SEL_EMPTY  = 5'd8;
    localparam logic [4:0] C_SEL_FRESH  = 5'd9;
    localparam logic [4:0] C_RM1        = 5'd10;
    localparam logic [4:0] C_RM2        = 5'd11;
    localparam logic [4:0] C_RM3        = 5'd12;
    localparam logic [4:0] C_PUSH1      = 5'd13;
    localparam logic [4:0] C_PUSH2      = 5'd14;
    localparam logic [4:0] C_POP        = 5'd15;
    localparam logic [4:0] C_POP_RD     = 5'd16;
    localparam logic [4:0] C_LATCH_SLOT = 5'd17;
    localparam logic [4:0] C_FREE_PUSH  = 5'd18;
    localparam logic [4:0] C_SHR_START  = 5'd19;
    localparam logic [4:0] C_SHR_STEP   = 5'd20;
    localparam logic [4:0] C_RES        = 5'd21;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] lst;
        logic [1:0] sts;
    } t_cmd;

    typedef struct packed {
        logic       cfg_ok;
        logic [1:0] op;
        logic       div_done;
        logic       part_avail;
        logic       empty_avail;
        logic       fresh_avail;
        logic       free_ok;
        logic       slot_ok;
        logic       stack_nonempty;
        logic       free_zero;
        logic       free_last;
        logic       free_full;
        logic       free_one;
        logic       shr_more;
        logic       out_free;
    } t_stat;

    typedef struct packed {
        logic [PGL_W-1:0] next;
        logic [PGL_W-1:0] prev;
        logic [SLC_W-1:0] free;
        logic [SLC_W-1:0] top;
        logic [SL_W-1:0]  hw;
    } t_rec;

endpackage

`default_nettype wire

[hw/rtl/slab_object_allocator_unit.sv]
// ----------------------------------------------------------------------------
// slab_object_allocator_unit
// Slab allocator for one object class over sixteen pages of 4096 bytes.
// ----------------------------------------------------------------------------
// Free runs the 13-step serial divider to find the slot; shrink releases one
// empty page per cycle; a request rejected at dispatch goes straight to the
// result, which waits until the output is free.
// Throughput: one transaction at a time; the next is taken once the result is
// registered. After reset or a configuration write, set-up runs the divider
// before a transaction is accepted; reset releases every page.
// ----------------------------------------------------------------------------
`default_nettype none

module slab_object_allocator_unit import soa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [PG_W-1:0]  i_free_page,
    input  wire logic [OFF_W-1:0] i_free_offset,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status,
    output logic [PG_W-1:0]       o_object_page,
    output logic [OFF_W-1:0]      o_object_offset,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [OBJ_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    soa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    soa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_free_page     (i_free_page),
        .i_free_offset   (i_free_offset),
        .i_out_ready     (i_out_ready),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_object_page   (o_object_page),
        .o_object_offset (o_object_offset)
    );

endmodule

`default_nettype wire

[hw/rtl/soa_ram.sv]
// ----------------------------------------------------------------------------
// soa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/soa_ctrl.sv]
// ----------------------------------------------------------------------------
// soa_ctrl
// Sequencer of the slab allocator: steps each operation through micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_ctrl import soa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_cfg_valid,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output logic       o_cfg_ready,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_CSTART  = 5'd0;
    localparam logic [4:0] S_CDIV    = 5'd1;
    localparam logic [4:0] S_CFIN    = 5'd2;
    localparam logic [4:0] S_IDLE    = 5'd3;
    localparam logic [4:0] S_DISP    = 5'd4;
    localparam logic [4:0] S_A_POP   = 5'd5;
    localparam logic [4:0] S_A_RD    = 5'd6;
    localparam logic [4:0] S_A_LIST  = 5'd7;
    localparam logic [4:0] S_A_TOFUL = 5'd8;
    localparam logic [4:0] S_RM1     = 5'd9;
    localparam logic [4:0] S_RM2     = 5'd10;
    localparam logic [4:0] S_RM3     = 5'd11;
    localparam logic [4:0] S_PUSH1   = 5'd12;
    localparam logic [4:0] S_PUSH2   = 5'd13;
    localparam logic [4:0] S_F_DIV   = 5'd14;
    localparam logic [4:0] S_F_CHK   = 5'd15;
    localparam logic [4:0] S_F_PUSH  = 5'd16;
    localparam logic [4:0] S_F_LIST  = 5'd17;
    localparam logic [4:0] S_SHR     = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;
    logic [1:0] r_lst, n_lst;
    logic [1:0] r_sts, n_sts;
    logic       r_moved, n_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CSTART;
            r_ret   <= S_IDLE;
            r_lst   <= LST_FULL;
            r_sts   <= ST_OK;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_lst   <= n_lst;
            r_sts   <= n_sts;
            r_moved <= n_moved;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_lst       = r_lst;
        n_sts       = r_sts;
        n_moved     = r_moved;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        o_cmd.op    = C_NOP;
        o_cmd.lst   = r_lst;
        o_cmd.sts   = r_sts;
        case (r_state)
            S_CSTART: begin
                o_cmd.op = C_CDIV_START;
                n_state  = S_CDIV;
            end
            S_CDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_CFIN;
                end else begin
                    o_cmd.op = C_DIV_STEP;
                end
            end
            S_CFIN: begin
                o_cmd.op = C_CFG_DONE;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_ready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.op = C_CFG_WR;
                    n_state  = S_CSTART;
                end else if (i_in_valid) begin
                    o_cmd.op = C_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                n_sts   = ST_INVALID;
                if (i_stat.cfg_ok) begin
                    case (i_stat.op)
                        OP_ALLOC: begin
                            if (i_stat.part_avail) begin
                                o_cmd.op = C_SEL_PART;
                                n_moved  = 1'b0;
                                n_state  = S_A_POP;
                            end else if (i_stat.empty_avail) begin
                                o_cmd.op = C_SEL_EMPTY;
                                n_moved  = 1'b1;
                                n_lst    = LST_EMPTY;
                                n_ret    = S_A_POP;
                                n_state  = S_RM1;
                            end else if (i_stat.fresh_avail) begin
                                o_cmd.op = C_SEL_FRESH;
                                n_moved  = 1'b1;
                                n_state  = S_A_POP;
                            end else begin
                                n_sts = ST_NOPAGE;
                            end
                        end
                        OP_FREE: begin
                            if (i_stat.free_ok) begin
                                o_cmd.op = C_FDIV_START;
                                n_state  = S_F_DIV;
                            end
                        end
                        OP_SHRINK: begin
                            o_cmd.op = C_SHR_START;
                            n_state  = S_SHR;
                        end
                        default: begin
                            n_sts = ST_INVALID;
                        end
                    endcase
                end
            end
            S_A_POP: begin
                o_cmd.op = C_POP;
                n_state  = i_stat.stack_nonempty ? S_A_RD : S_A_LIST;
            end
            S_A_RD: begin
                o_cmd.op = C_POP_RD;
                n_state  = S_A_LIST;
            end
            S_A_LIST: begin
                n_sts = ST_OK;
                if (r_moved) begin
                    n_lst   = i_stat.free_zero ? LST_FULL : LST_PARTIAL;
                    n_state = S_PUSH1;
                end else if (i_stat.free_zero) begin
                    n_lst   = LST_PARTIAL;
                    n_ret   = S_A_TOFUL;
                    n_state = S_RM1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_TOFUL: begin
                n_lst   = LST_FULL;
                n_state = S_PUSH1;
            end
            S_RM1: begin
                o_cmd.op = C_RM1;
                n_state  = S_RM2;
            end
            S_RM2: begin
                o_cmd.op = C_RM2;
                n_state  = S_RM3;
            end
            S_RM3: begin
                o_cmd.op = C_RM3;
                n_state  = r_ret;
            end
            S_PUSH1: begin
                o_cmd.op = C_PUSH1;
                n_state  = S_PUSH2;
            end
            S_PUSH2: begin
                o_cmd.op = C_PUSH2;
                n_sts    = ST_OK;
                n_state  = S_DONE;
            end
            S_F_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_F_CHK;
                end else begin
                    o_cmd.op = C_DIV_STEP;
                end
            end
            S_F_CHK: begin
                o_cmd.op = C_LATCH_SLOT;
                n_ret    = S_F_PUSH;
                if (!i_stat.slot_ok) begin
                    n_sts   = ST_INVALID;
                    n_state = S_DONE;
                end else if (i_stat.free_zero) begin
                    n_lst   = LST_FULL;
                    n_state = S_RM1;
                end else if (i_stat.free_last) begin
                    n_lst   = LST_PARTIAL;
                    n_state = S_RM1;
                end else begin
                    n_state = S_F_PUSH;
                end
            end
            S_F_PUSH: begin
                o_cmd.op = C_FREE_PUSH;
                n_state  = S_F_LIST;
            end
            S_F_LIST: begin
                n_sts = ST_OK;
                if (i_stat.free_full) begin
                    n_lst   = LST_EMPTY;
                    n_state = S_PUSH1;
                end else if (i_stat.free_one) begin
                    n_lst   = LST_PARTIAL;
                    n_state = S_PUSH1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHR: begin
                if (i_stat.shr_more) begin
                    o_cmd.op = C_SHR_STEP;
                end else begin
                    n_sts   = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = C_RES;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/soa_dpath.sv]
// ----------------------------------------------------------------------------
// soa_dpath
// Datapath of the slab allocator: configuration, page records, list heads,
// serial divider, slot link memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_dpath import soa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [OBJ_W-1:0] i_cfg_data,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [PG_W-1:0]  i_free_page,
    input  wire logic [OFF_W-1:0] i_free_offset,
    input  wire logic             i_out_ready,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [PG_W-1:0]       o_object_page,
    output logic [OFF_W-1:0]      o_object_offset
);

    logic [OBJ_W-1:0]     r_obj;
    logic [ALG_W-1:0]     r_alg;
    logic [OFF_W-1:0]     r_pb;
    logic [DIV_W-1:0]     r_sz;
    logic [SLC_W-1:0]     r_n;
    logic                 r_pre;
    logic                 r_cfg_ok;

    logic [1:0]           r_op;
    logic [PG_W-1:0]      r_fpage;
    logic [OFF_W-1:0]     r_foff;

    logic [NUM_PAGES-1:0] r_in_use;
    t_rec                 r_rec [NUM_PAGES];
    logic [PGL_W-1:0]     r_head_full;
    logic [PGL_W-1:0]     r_head_part;
    logic [PGL_W-1:0]     r_head_empty;

    logic [PG_W-1:0]      r_p;
    logic [PGL_W-1:0]     r_pv;
    logic [PGL_W-1:0]     r_nx;
    logic [PGL_W-1:0]     r_nb;
    logic [PGL_W-1:0]     r_shp;
    logic [PGL_W-1:0]     r_guard;
    logic [SL_W-1:0]      r_slot;

    logic [DIV_W-1:0]     r_dq;
    logic [DIV_W-1:0]     r_drem;
    logic [DIV_W-1:0]     r_dvs;
    logic [3:0]           r_dcnt;

    logic [WIDE_W-1:0]    w_a;
    logic [WIDE_W-1:0]    w_pb;
    logic [WIDE_W-1:0]    w_szr;
    logic [WIDE_W-1:0]    w_sz;
    logic                 w_pre;
    logic [DIV_W:0]       w_trial;
    logic                 w_ge;
    logic [PG_W-1:0]      w_fresh;
    logic                 w_fresh_ok;
    logic [PGL_W-1:0]     w_lhead;
    t_rec                 w_cur;
    logic [SLC_W-1:0]     w_ram_q;
    logic                 w_ram_we;
    logic                 w_ram_re;
    logic [PG_W+SL_W-1:0] w_ram_waddr;
    logic [PG_W+SL_W-1:0] w_ram_raddr;
    logic [SL_W+DIV_W-1:0] w_prod;

    always_comb begin
        w_a   = WIDE_W'(1) << r_alg;
        w_pb  = (WIDE_W'(HEADER_BYTES) + w_a - WIDE_W'(1)) & ~(w_a - WIDE_W'(1));
        w_szr = (WIDE_W'(r_obj) + w_a - WIDE_W'(1)) & ~(w_a - WIDE_W'(1));
        w_sz  = (w_szr < WIDE_W'(4)) ? WIDE_W'(4) : w_szr;
        w_pre = (r_obj != '0) && (w_pb < WIDE_W'(PAGE_BYTES))
                && (w_sz <= WIDE_W'(PAGE_BYTES) - w_pb);
    end

    assign w_trial = {r_drem, r_dq[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_comb begin
        w_fresh    = '0;
        w_fresh_ok = 1'b0;
        for (int i = NUM_PAGES - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_fresh    = PG_W'(i);
                w_fresh_ok = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.lst)
            LST_FULL:    w_lhead = r_head_full;
            LST_PARTIAL: w_lhead = r_head_part;
            default:     w_lhead = r_head_empty;
        endcase
    end

    assign w_cur = r_rec[r_p];

    assign w_ram_we    = (i_cmd.op == C_FREE_PUSH);
    assign w_ram_waddr = {r_p, r_slot};
    assign w_ram_re    = (i_cmd.op == C_POP);
    assign w_ram_raddr = {r_p, w_cur.top[SL_W-1:0]};

    soa_ram #(
        .WIDTH (SLC_W),
        .DEPTH (NUM_PAGES * MAX_SLOTS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_cur.top),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_prod = SL_W'(r_slot) * r_sz;

    always_comb begin
        o_stat.cfg_ok         = r_cfg_ok;
        o_stat.op             = r_op;
        o_stat.div_done       = (r_dcnt == '0);
        o_stat.part_avail     = !r_head_part[PG_W];
        o_stat.empty_avail    = !r_head_empty[PG_W];
        o_stat.fresh_avail    = w_fresh_ok;
        o_stat.free_ok        = r_in_use[r_fpage] && (r_foff >= r_pb);
        o_stat.slot_ok        = (r_dq < DIV_W'(r_n)) && (w_cur.free < r_n);
        o_stat.stack_nonempty = !w_cur.top[SL_W];
        o_stat.free_zero      = (w_cur.free == '0);
        o_stat.free_last      = ((w_cur.free + SLC_W'(1)) == r_n);
        o_stat.free_full      = (w_cur.free == r_n);
        o_stat.free_one       = (w_cur.free == SLC_W'(1));
        o_stat.shr_more       = !r_shp[PG_W] && !r_guard[PG_W];
        o_stat.out_free       = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj        <= OBJ_W'(8);
            r_alg        <= ALG_W'(3);
            r_cfg_ok     <= 1'b0;
            r_in_use     <= '0;
            r_head_full  <= PG_NONE;
            r_head_part  <= PG_NONE;
            r_head_empty <= PG_NONE;
            r_dcnt       <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready && (i_cmd.op != C_RES)) begin
                o_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                C_LOAD: begin
                    r_op    <= i_opcode;
                    r_fpage <= i_free_page;
                    r_foff  <= i_free_offset;
                end
                C_CFG_WR: begin
                    if (i_cfg_index == REG_OBJECT_BYTES) begin
                        r_obj <= i_cfg_data;
                    end else begin
                        r_alg <= i_cfg_data[ALG_W-1:0];
                    end
                    r_cfg_ok     <= 1'b0;
                    r_in_use     <= '0;
                    r_head_full  <= PG_NONE;
                    r_head_part  <= PG_NONE;
                    r_head_empty <= PG_NONE;
                end
                C_CDIV_START: begin
                    r_pb   <= w_pb[OFF_W-1:0];
                    r_sz   <= w_sz[DIV_W-1:0];
                    r_dvs  <= w_sz[DIV_W-1:0];
                    r_pre  <= w_pre;
                    r_dq   <= DIV_W'(PAGE_BYTES) - DIV_W'(w_pb[OFF_W-1:0]);
                    r_drem <= '0;
                    r_dcnt <= 4'(DIV_W);
                end
                C_DIV_STEP: begin
                    r_drem <= w_ge ? DIV_W'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_W-1:0];
                    r_dq   <= {r_dq[DIV_W-2:0], w_ge};
                    r_dcnt <= r_dcnt - 4'd1;
                end
                C_CFG_DONE: begin
                    r_n      <= (r_dq > DIV_W'(MAX_SLOTS)) ? SL_NONE : r_dq[SLC_W-1:0];
                    r_cfg_ok <= r_pre && (r_dq != '0);
                end
                C_FDIV_START: begin
                    r_p    <= r_fpage;
                    r_dvs  <= r_sz;
                    r_dq   <= DIV_W'(r_foff - r_pb);
                    r_drem <= '0;
                    r_dcnt <= 4'(DIV_W);
                end
                C_SEL_PART: begin
                    r_p <= r_head_part[PG_W-1:0];
                end
                C_SEL_EMPTY: begin
                    r_p <= r_head_empty[PG_W-1:0];
                end
                C_SEL_FRESH: begin
                    r_p                <= w_fresh;
                    r_in_use[w_fresh]  <= 1'b1;
                    r_rec[w_fresh].next <= PG_NONE;
                    r_rec[w_fresh].prev <= PG_NONE;
                    r_rec[w_fresh].free <= r_n;
                    r_rec[w_fresh].top  <= SL_NONE;
                    r_rec[w_fresh].hw   <= '0;
                end
                C_RM1: begin
                    r_pv            <= w_cur.prev;
                    r_nx            <= w_cur.next;
                    r_rec[r_p].next <= PG_NONE;
                    r_rec[r_p].prev <= PG_NONE;
                    if (w_cur.prev[PG_W] && (w_lhead == {1'b0, r_p})) begin
                        case (i_cmd.lst)
                            LST_FULL:    r_head_full  <= w_cur.next;
                            LST_PARTIAL: r_head_part  <= w_cur.next;
                            default:     r_head_empty <= w_cur.next;
                        endcase
                    end
                end
                C_RM2: begin
                    if (!r_pv[PG_W]) begin
                        r_rec[r_pv[PG_W-1:0]].next <= r_nx;
                    end
                end
                C_RM3: begin
                    if (!r_nx[PG_W]) begin
                        r_rec[r_nx[PG_W-1:0]].prev <= r_pv;
                    end
                end
                C_PUSH1: begin
                    r_rec[r_p].next <= w_lhead;
                    r_rec[r_p].prev <= PG_NONE;
                    r_nb            <= w_lhead;
                    case (i_cmd.lst)
                        LST_FULL:    r_head_full  <= {1'b0, r_p};
                        LST_PARTIAL: r_head_part  <= {1'b0, r_p};
                        default:     r_head_empty <= {1'b0, r_p};
                    endcase
                end
                C_PUSH2: begin
                    if (!r_nb[PG_W]) begin
                        r_rec[r_nb[PG_W-1:0]].prev <= {1'b0, r_p};
                    end
                end
                C_POP: begin
                    if (!w_cur.top[SL_W]) begin
                        r_slot <= w_cur.top[SL_W-1:0];
                    end else begin
                        r_slot          <= w_cur.hw;
                        r_rec[r_p].hw   <= w_cur.hw + SL_W'(1);
                        r_rec[r_p].free <= w_cur.free - SLC_W'(1);
                    end
                end
                C_POP_RD: begin
                    r_rec[r_p].top  <= w_ram_q;
                    r_rec[r_p].free <= w_cur.free - SLC_W'(1);
                end
                C_LATCH_SLOT: begin
                    r_slot <= r_dq[SL_W-1:0];
                end
                C_FREE_PUSH: begin
                    r_rec[r_p].top  <= {1'b0, r_slot};
                    r_rec[r_p].free <= w_cur.free + SLC_W'(1);
                end
                C_SHR_START: begin
                    r_shp        <= r_head_empty;
                    r_head_empty <= PG_NONE;
                    r_guard      <= '0;
                end
                C_SHR_STEP: begin
                    r_shp                        <= r_rec[r_shp[PG_W-1:0]].next;
                    r_in_use[r_shp[PG_W-1:0]]    <= 1'b0;
                    r_rec[r_shp[PG_W-1:0]].next  <= PG_NONE;
                    r_rec[r_shp[PG_W-1:0]].prev  <= PG_NONE;
                    r_guard                      <= r_guard + PGL_W'(1);
                end
                C_RES: begin
                    o_out_valid <= 1'b1;
                    o_status    <= i_cmd.sts;
                    if ((i_cmd.sts == ST_OK) && (r_op == OP_ALLOC)) begin
                        o_object_page   <= r_p;
                        o_object_offset <= r_pb + w_prod[OFF_W-1:0];
                    end else begin
                        o_object_page   <= '0;
                        o_object_offset <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
